>>> hdl/complex_arithmetic_unit_macros.svh
// assertion macros for the complex arithmetic unit
// expects signals named clk and rst_n in the module that uses them
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// consequent must hold in the same cycle
`define CAU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the following cycle
`define CAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cau_pkg.sv
// shared operation codes and pipeline control type for the complex arithmetic unit
// no dependencies
package cau_pkg;

    // operation codes
    localparam logic [3:0] KIND_ADD   = 4'd0;
    localparam logic [3:0] KIND_SUB   = 4'd1;
    localparam logic [3:0] KIND_MUL   = 4'd2;
    localparam logic [3:0] KIND_DIV   = 4'd3;
    localparam logic [3:0] KIND_CONJ  = 4'd4;
    localparam logic [3:0] KIND_NEG   = 4'd5;
    localparam logic [3:0] KIND_NORM  = 4'd6;
    localparam logic [3:0] KIND_MAG   = 4'd7;
    localparam logic [3:0] KIND_EQUAL = 4'd8;

    // control bits that travel with each item down the pipeline
    typedef struct packed {
        logic       valid;
        logic [3:0] kind;
        logic       eq;
        logic       ov;
        logic       dz;
        logic       neg_re;
        logic       neg_im;
        logic       big_re;
        logic       big_im;
    } cau_ctrl_t;

endpackage

>>> hdl/cau_iter_stage.sv
// one registered step of the quotient and square root arrays
// depends on cau_pkg
module cau_iter_stage #(
    parameter int W   = 32,
    parameter int NW  = 98,
    parameter int RW  = 66,
    parameter int BIT = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  cau_pkg::cau_ctrl_t  src_ctrl,
    input  logic [NW-1:0]       src_rem_re,
    input  logic [NW-1:0]       src_rem_im,
    input  logic [W:0]          src_q_re,
    input  logic [W:0]          src_q_im,
    input  logic [2*W-1:0]      src_den,
    input  logic [RW-1:0]       src_srem,
    input  logic [W-1:0]        src_root,
    input  logic [W-1:0]        src_ere,
    input  logic [W-1:0]        src_eim,
    output cau_pkg::cau_ctrl_t  dst_ctrl,
    output logic [NW-1:0]       dst_rem_re,
    output logic [NW-1:0]       dst_rem_im,
    output logic [W:0]          dst_q_re,
    output logic [W:0]          dst_q_im,
    output logic [2*W-1:0]      dst_den,
    output logic [RW-1:0]       dst_srem,
    output logic [W-1:0]        dst_root,
    output logic [W-1:0]        dst_ere,
    output logic [W-1:0]        dst_eim
);

    cau_pkg::cau_ctrl_t ctrl_reg;
    logic [NW-1:0]  rem_re_reg, rem_re_next;
    logic [NW-1:0]  rem_im_reg, rem_im_next;
    logic [W:0]     q_re_reg, q_re_next;
    logic [W:0]     q_im_reg, q_im_next;
    logic [2*W-1:0] den_reg;
    logic [RW-1:0]  srem_reg, srem_next;
    logic [W-1:0]   root_reg, root_next;
    logic [W-1:0]   ere_reg;
    logic [W-1:0]   eim_reg;
    logic [NW-1:0]  dsh;
    logic           take_re;
    logic           take_im;

    // restoring division, one quotient bit for each part
    always_comb
    begin
        dsh         = NW'(src_den) << BIT;
        take_re     = src_rem_re >= dsh;
        take_im     = src_rem_im >= dsh;
        rem_re_next = take_re ? src_rem_re - dsh : src_rem_re;
        rem_im_next = take_im ? src_rem_im - dsh : src_rem_im;
        q_re_next   = src_q_re;
        q_im_next   = src_q_im;
        q_re_next[BIT] = take_re;
        q_im_next[BIT] = take_im;
    end

    // one root bit per stage, the last stage only passes the root on
    generate
        if (BIT >= 1) begin : g_root
            localparam int SB = BIT - 1;
            logic [RW-1:0] trial;
            logic          take_sq;
            always_comb
            begin
                trial     = (RW'(src_root) << (SB + 1)) + (RW'(1) << (2 * SB));
                take_sq   = src_srem >= trial;
                srem_next = take_sq ? src_srem - trial : src_srem;
                root_next = src_root;
                root_next[SB] = take_sq;
            end
        end else begin : g_pass
            always_comb
            begin
                srem_next = src_srem;
                root_next = src_root;
            end
        end
    endgenerate

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= src_ctrl;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            q_re_reg   <= q_re_next;
            q_im_reg   <= q_im_next;
            den_reg    <= src_den;
            srem_reg   <= srem_next;
            root_reg   <= root_next;
            ere_reg    <= src_ere;
            eim_reg    <= src_eim;
        end
    end

    assign dst_ctrl   = ctrl_reg;
    assign dst_rem_re = rem_re_reg;
    assign dst_rem_im = rem_im_reg;
    assign dst_q_re   = q_re_reg;
    assign dst_q_im   = q_im_reg;
    assign dst_den    = den_reg;
    assign dst_srem   = srem_reg;
    assign dst_root   = root_reg;
    assign dst_ere    = ere_reg;
    assign dst_eim    = eim_reg;

endmodule

>>> hdl/complex_arithmetic_unit.sv
// complex arithmetic unit on signed fixed-point operands, fully pipelined
// depends on cau_pkg, cau_iter_stage and complex_arithmetic_unit_macros.svh
//
// Usage:
//   request channel: req_valid / req_stall with kind, a_re, a_im, b_re, b_im.
//   response channel: rsp_valid / rsp_stall with res_re, res_im, is_equal,
//   overflowed and divide_by_zero. A transfer happens when valid is high
//   and stall is low.
//   Throughput is one transfer per cycle while the receiver does not stall
//   a waiting result. The depth comes from the divider and square root
//   arrays, DATA_WIDTH + 1 stages with one quotient bit per stage and one
//   root bit per stage but the last, which only passes the root on; they
//   follow four stages of operand capture, multiplication, summing and
//   rounding, then one output register.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   req_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits; no results are pending afterwards and the
//   block accepts a request in the first cycle after reset.
//   Only the low DATA_WIDTH bits of each operand are used; results come out
//   as DATA_WIDTH-bit two's complement.
`include "complex_arithmetic_unit_macros.svh"

module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [3:0]         kind,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    input  logic signed [31:0] b_re,
    input  logic signed [31:0] b_im,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [31:0] res_re,
    output logic signed [31:0] res_im,
    output logic               is_equal,
    output logic               overflowed,
    output logic               divide_by_zero
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int NW = 2 * W + ((FRAC_BITS > W + 1) ? FRAC_BITS : W + 1) + 2;
    localparam int RW = 2 * W + 2;
    localparam int NS = W + 1;
    localparam logic [SW:0] HALF = ((SW + 1)'(1) << FRAC_BITS) >> 1;

    // saturate a magnitude with sign to W bits, overflow flag on top
    function automatic logic [W:0] sat_mag(input logic neg, input logic [NW-1:0] m);
        logic [NW-1:0] limit;
        logic [W-1:0]  v;
        logic          ov;
        limit = neg ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - NW'(1));
        ov    = m > limit;
        v     = ov ? limit[W-1:0] : m[W-1:0];
        if (neg)
        begin
            v = -v;
        end
        sat_mag = {ov, v};
    endfunction

    logic en;

    // stage 1: operand capture
    cau_pkg::cau_ctrl_t  s1_ctrl_reg, s1_ctrl_next;
    logic signed [W-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [63:0]  ar_x, ai_x, br_x, bi_x;

    // stage 2: products and simple operations
    cau_pkg::cau_ctrl_t   s2_ctrl_reg, s2_ctrl_next;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, q1_reg, q2_reg;
    logic signed [PW-1:0] p1_next, p2_next, p3_next, p4_next, q1_next, q2_next;
    logic signed [W-1:0]  mx, my;
    logic signed [W:0]    e_re, e_im;
    logic [W:0]           e_re_mag, e_im_mag;
    logic [W-1:0]         ere2_reg, eim2_reg, ere2_next, eim2_next;
    logic                 e_ov_re, e_ov_im;

    // stage 3: sums
    cau_pkg::cau_ctrl_t   s3_ctrl_reg;
    logic signed [SW-1:0] t_re_reg, t_im_reg, t_re_next, t_im_next;
    logic [PW-1:0]        den3_reg, den3_next;
    logic [W-1:0]         ere3_reg, eim3_reg;

    // stage 4: rounding and array setup
    cau_pkg::cau_ctrl_t s4_ctrl_reg, s4_ctrl_next;
    logic [SW-1:0]      t_re_mag, t_im_mag;
    logic [SW:0]        rnd_re, rnd_im, rnd_nm;
    logic [NW-1:0]      m_re, m_im, dbig;
    logic [W-1:0]       m_sat_re, m_sat_im, n_sat;
    logic               m_ov_re, m_ov_im, n_ov;
    logic [NW-1:0]      rem_re4_reg, rem_im4_reg;
    logic [PW-1:0]      den4_reg;
    logic [W-1:0]       ere4_reg, eim4_reg, ere4_next, eim4_next;

    // array taps, index 0 fed from stage 4
    cau_pkg::cau_ctrl_t it_ctrl   [0:NS];
    logic [NW-1:0]      it_rem_re [0:NS];
    logic [NW-1:0]      it_rem_im [0:NS];
    logic [W:0]         it_q_re   [0:NS];
    logic [W:0]         it_q_im   [0:NS];
    logic [PW-1:0]      it_den    [0:NS];
    logic [RW-1:0]      it_srem   [0:NS];
    logic [W-1:0]       it_root   [0:NS];
    logic [W-1:0]       it_ere    [0:NS];
    logic [W-1:0]       it_eim    [0:NS];

    // output stage
    cau_pkg::cau_ctrl_t fin_c;
    logic               rnd_q_re, rnd_q_im, rnd_sq;
    logic [W-1:0]       d_re, d_im, sq_val;
    logic               d_ov_re, d_ov_im, sq_ov;
    logic               out_valid_reg;
    logic [W-1:0]       out_re_reg, out_re_next, out_im_reg, out_im_next;
    logic               out_eq_reg, out_eq_next, out_ov_reg, out_ov_next;
    logic               out_dz_reg, out_dz_next;
    logic [63:0]        out_re_x, out_im_x;

    // the whole pipeline advances unless a finished result is held back
    assign en        = !(out_valid_reg && rsp_stall);
    assign req_stall = !en;

    // stage 1: take the low bits of each operand
    always_comb
    begin
        ar_x = 64'(a_re);
        ai_x = 64'(a_im);
        br_x = 64'(b_re);
        bi_x = 64'(b_im);
        s1_ctrl_next       = '0;
        s1_ctrl_next.valid = req_valid;
        s1_ctrl_next.kind  = kind;
    end

    // stage 2: operand selection, products, simple operations
    always_comb
    begin
        mx = (s1_ctrl_reg.kind == cau_pkg::KIND_DIV) ? br1_reg : ar1_reg;
        my = (s1_ctrl_reg.kind == cau_pkg::KIND_DIV) ? bi1_reg : ai1_reg;
        p1_next = ar1_reg * br1_reg;
        p2_next = ai1_reg * bi1_reg;
        p3_next = ar1_reg * bi1_reg;
        p4_next = ai1_reg * br1_reg;
        q1_next = mx * mx;
        q2_next = my * my;

        e_re = '0;
        e_im = '0;
        case (s1_ctrl_reg.kind)
            cau_pkg::KIND_ADD:
            begin
                e_re = (W + 1)'(ar1_reg) + (W + 1)'(br1_reg);
                e_im = (W + 1)'(ai1_reg) + (W + 1)'(bi1_reg);
            end
            cau_pkg::KIND_SUB:
            begin
                e_re = (W + 1)'(ar1_reg) - (W + 1)'(br1_reg);
                e_im = (W + 1)'(ai1_reg) - (W + 1)'(bi1_reg);
            end
            cau_pkg::KIND_CONJ:
            begin
                e_re = (W + 1)'(ar1_reg);
                e_im = -(W + 1)'(ai1_reg);
            end
            cau_pkg::KIND_NEG:
            begin
                e_re = -(W + 1)'(ar1_reg);
                e_im = -(W + 1)'(ai1_reg);
            end
            default:
            begin
                e_re = '0;
                e_im = '0;
            end
        endcase
        e_re_mag = e_re[W] ? -e_re : e_re;
        e_im_mag = e_im[W] ? -e_im : e_im;
        {e_ov_re, ere2_next} = sat_mag(e_re[W], NW'(e_re_mag));
        {e_ov_im, eim2_next} = sat_mag(e_im[W], NW'(e_im_mag));

        s2_ctrl_next    = s1_ctrl_reg;
        s2_ctrl_next.eq = (s1_ctrl_reg.kind == cau_pkg::KIND_EQUAL)
                          && (ar1_reg == br1_reg) && (ai1_reg == bi1_reg);
        s2_ctrl_next.ov = e_ov_re | e_ov_im;
        s2_ctrl_next.dz = (s1_ctrl_reg.kind == cau_pkg::KIND_DIV)
                          && (br1_reg == '0) && (bi1_reg == '0);
    end

    // stage 3: multiply or divide numerators, and the norm
    always_comb
    begin
        if (s2_ctrl_reg.kind == cau_pkg::KIND_MUL)
        begin
            t_re_next = SW'(p1_reg) - SW'(p2_reg);
            t_im_next = SW'(p3_reg) + SW'(p4_reg);
        end
        else
        begin
            t_re_next = SW'(p1_reg) + SW'(p2_reg);
            t_im_next = SW'(p4_reg) - SW'(p3_reg);
        end
        den3_next = $unsigned(q1_reg) + $unsigned(q2_reg);
    end

    // stage 4: rounding of products, divider and root setup
    always_comb
    begin
        t_re_mag = t_re_reg[SW-1] ? -t_re_reg : t_re_reg;
        t_im_mag = t_im_reg[SW-1] ? -t_im_reg : t_im_reg;
        rnd_re   = ((SW + 1)'(t_re_mag) + HALF) >> FRAC_BITS;
        rnd_im   = ((SW + 1)'(t_im_mag) + HALF) >> FRAC_BITS;
        rnd_nm   = ((SW + 1)'(den3_reg) + HALF) >> FRAC_BITS;
        {m_ov_re, m_sat_re} = sat_mag(t_re_reg[SW-1], NW'(rnd_re));
        {m_ov_im, m_sat_im} = sat_mag(t_im_reg[SW-1], NW'(rnd_im));
        {n_ov, n_sat}       = sat_mag(1'b0, NW'(rnd_nm));

        m_re = NW'(t_re_mag) << FRAC_BITS;
        m_im = NW'(t_im_mag) << FRAC_BITS;
        dbig = NW'(den3_reg) << (W + 1);

        s4_ctrl_next        = s3_ctrl_reg;
        s4_ctrl_next.neg_re = t_re_reg[SW-1];
        s4_ctrl_next.neg_im = t_im_reg[SW-1];
        s4_ctrl_next.big_re = m_re >= dbig;
        s4_ctrl_next.big_im = m_im >= dbig;
        ere4_next = ere3_reg;
        eim4_next = eim3_reg;
        case (s3_ctrl_reg.kind)
            cau_pkg::KIND_MUL:
            begin
                ere4_next       = m_sat_re;
                eim4_next       = m_sat_im;
                s4_ctrl_next.ov = m_ov_re | m_ov_im;
            end
            cau_pkg::KIND_NORM:
            begin
                ere4_next       = n_sat;
                eim4_next       = '0;
                s4_ctrl_next.ov = n_ov;
            end
            default:
            begin
                ere4_next = ere3_reg;
                eim4_next = eim3_reg;
            end
        endcase
    end

    // control registers of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            s3_ctrl_reg <= '0;
            s4_ctrl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s2_ctrl_reg <= s2_ctrl_next;
            s3_ctrl_reg <= s2_ctrl_reg;
            s4_ctrl_reg <= s4_ctrl_next;
        end
    end

    // payload registers of the front stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ar1_reg     <= ar_x[W-1:0];
            ai1_reg     <= ai_x[W-1:0];
            br1_reg     <= br_x[W-1:0];
            bi1_reg     <= bi_x[W-1:0];
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            p3_reg      <= p3_next;
            p4_reg      <= p4_next;
            q1_reg      <= q1_next;
            q2_reg      <= q2_next;
            ere2_reg    <= ere2_next;
            eim2_reg    <= eim2_next;
            t_re_reg    <= t_re_next;
            t_im_reg    <= t_im_next;
            den3_reg    <= den3_next;
            ere3_reg    <= ere2_reg;
            eim3_reg    <= eim2_reg;
            rem_re4_reg <= m_re;
            rem_im4_reg <= m_im;
            den4_reg    <= den3_reg;
            ere4_reg    <= ere4_next;
            eim4_reg    <= eim4_next;
        end
    end

    // feed the arrays
    assign it_ctrl[0]   = s4_ctrl_reg;
    assign it_rem_re[0] = rem_re4_reg;
    assign it_rem_im[0] = rem_im4_reg;
    assign it_q_re[0]   = '0;
    assign it_q_im[0]   = '0;
    assign it_den[0]    = den4_reg;
    assign it_srem[0]   = RW'(den4_reg);
    assign it_root[0]   = '0;
    assign it_ere[0]    = ere4_reg;
    assign it_eim[0]    = eim4_reg;

    // quotient and root arrays, most significant bit first
    generate
        for (genvar k = 0; k < NS; k++) begin : g_iter
            cau_iter_stage #(
                .W   (W),
                .NW  (NW),
                .RW  (RW),
                .BIT (W - k)
            ) u_stage (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (en),
                .src_ctrl   (it_ctrl[k]),
                .src_rem_re (it_rem_re[k]),
                .src_rem_im (it_rem_im[k]),
                .src_q_re   (it_q_re[k]),
                .src_q_im   (it_q_im[k]),
                .src_den    (it_den[k]),
                .src_srem   (it_srem[k]),
                .src_root   (it_root[k]),
                .src_ere    (it_ere[k]),
                .src_eim    (it_eim[k]),
                .dst_ctrl   (it_ctrl[k+1]),
                .dst_rem_re (it_rem_re[k+1]),
                .dst_rem_im (it_rem_im[k+1]),
                .dst_q_re   (it_q_re[k+1]),
                .dst_q_im   (it_q_im[k+1]),
                .dst_den    (it_den[k+1]),
                .dst_srem   (it_srem[k+1]),
                .dst_root   (it_root[k+1]),
                .dst_ere    (it_ere[k+1]),
                .dst_eim    (it_eim[k+1])
            );
        end
    endgenerate

    // final rounding, saturation and selection by operation
    always_comb
    begin
        fin_c    = it_ctrl[NS];
        rnd_q_re = (it_rem_re[NS] << 1) >= NW'(it_den[NS]);
        rnd_q_im = (it_rem_im[NS] << 1) >= NW'(it_den[NS]);
        rnd_sq   = it_srem[NS] > RW'(it_root[NS]);
        if (fin_c.big_re)
        begin
            {d_ov_re, d_re} = sat_mag(fin_c.neg_re, '1);
        end
        else
        begin
            {d_ov_re, d_re} = sat_mag(fin_c.neg_re, NW'(it_q_re[NS]) + NW'(rnd_q_re));
        end
        if (fin_c.big_im)
        begin
            {d_ov_im, d_im} = sat_mag(fin_c.neg_im, '1);
        end
        else
        begin
            {d_ov_im, d_im} = sat_mag(fin_c.neg_im, NW'(it_q_im[NS]) + NW'(rnd_q_im));
        end
        {sq_ov, sq_val} = sat_mag(1'b0, NW'(it_root[NS]) + NW'(rnd_sq));

        out_eq_next = fin_c.eq;
        out_dz_next = fin_c.dz;
        case (fin_c.kind)
            cau_pkg::KIND_DIV:
            begin
                if (fin_c.dz)
                begin
                    out_re_next = '0;
                    out_im_next = '0;
                    out_ov_next = 1'b0;
                end
                else
                begin
                    out_re_next = d_re;
                    out_im_next = d_im;
                    out_ov_next = d_ov_re | d_ov_im;
                end
            end
            cau_pkg::KIND_MAG:
            begin
                out_re_next = sq_val;
                out_im_next = '0;
                out_ov_next = sq_ov;
            end
            default:
            begin
                out_re_next = it_ere[NS];
                out_im_next = it_eim[NS];
                out_ov_next = fin_c.ov;
            end
        endcase
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fin_c.valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_re_reg <= out_re_next;
            out_im_reg <= out_im_next;
            out_eq_reg <= out_eq_next;
            out_ov_reg <= out_ov_next;
            out_dz_reg <= out_dz_next;
        end
    end

    // results leave as DATA_WIDTH-bit patterns
    assign out_re_x       = 64'(out_re_reg);
    assign out_im_x       = 64'(out_im_reg);
    assign rsp_valid      = out_valid_reg;
    assign res_re         = out_re_x[31:0];
    assign res_im         = out_im_x[31:0];
    assign is_equal       = out_eq_reg;
    assign overflowed     = out_ov_reg;
    assign divide_by_zero = out_dz_reg;

    // checks
    `CAU_ASSERT_SAME(a_dz_zero, rsp_valid && divide_by_zero, (res_re == '0) && (res_im == '0) && !overflowed, "divide by zero result not cleared")
    `CAU_ASSERT_SAME(a_eq_clean, rsp_valid && is_equal, (res_re == '0) && (res_im == '0) && !overflowed && !divide_by_zero, "equal result carries other data")
    `CAU_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, $stable(s1_ctrl_reg) && $stable(it_ctrl[NS]), "pipeline moved during stall")

endmodule
